// ===== rtl/dcs_pkg.sv =====
// dcs_pkg: shared types and codes for the dshot direction change sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package dcs_pkg;

  localparam int MOTORS_DEF = 4;

  // request types
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MOTOR = 2'd1;
  localparam logic [1:0] ST_BAD_DIR   = 2'd2;
  localparam logic [1:0] ST_BUSY      = 2'd3;

  // sequence phases
  localparam logic [2:0] PH_IDLE1 = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_IDLE2 = 3'd2;
  localparam logic [2:0] PH_SAVE  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_IDLE_TICKS     = 3'd0;
  localparam logic [2:0] REG_CMD_GAP_TICKS  = 3'd1;
  localparam logic [2:0] REG_SAVE_GAP_TICKS = 3'd2;
  localparam logic [2:0] REG_REPEAT_COUNT   = 3'd3;
  localparam logic [2:0] REG_DIR_ONE_CODE   = 3'd4;
  localparam logic [2:0] REG_DIR_TWO_CODE   = 3'd5;
  localparam logic [2:0] REG_SAVE_CODE      = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  motor;
    logic [5:0]  direction;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bus_idle;
    logic       write_valid;
    logic [5:0] write_value;
    logic       changing;
  } out_item_t;

  typedef struct packed {
    logic [15:0] idle_ticks;
    logic [15:0] cmd_gap_ticks;
    logic [15:0] save_gap_ticks;
    logic [3:0]  repeat_count;
    logic [5:0]  dir_one_code;
    logic [5:0]  dir_two_code;
    logic [5:0]  save_code;
  } cfg_t;

  // per-motor record; all-zero is the reset record
  typedef struct packed {
    logic [2:0]  phase;
    logic        busy;
    logic [3:0]  sent_count;
    logic [31:0] phase_start;
    logic [5:0]  target_code;
    logic [5:0]  dir_setting;
    logic        idle;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/dcs_rec_mem.sv =====
// dcs_rec_mem: per-motor record memory with registered read, valid bits and
// forwarding of the most recent write; depends on dcs_pkg
`default_nettype none

module dcs_rec_mem
  import dcs_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEF,
  parameter int IDX_W  = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire rec_t             wr_rec,
  output rec_t                  rd_rec
);

  rec_t             mem [MOTORS];
  logic [MOTORS-1:0] written;
  rec_t             rd_q;
  logic             rd_written;
  logic [IDX_W-1:0] rd_addr_q;
  rec_t             fwd_rec;
  logic [IDX_W-1:0] fwd_addr;
  logic             fwd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
      fwd_rec      <= wr_rec;
      fwd_addr     <= wr_addr;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
        fwd_valid        <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // latest write wins over the memory copy read in the same cycle
  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr_q)) begin
      rd_rec = fwd_rec;
    end else if (rd_written) begin
      rd_rec = rd_q;
    end else begin
      rd_rec = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcs_step.sv =====
// dcs_step: request checks and phase advance for one motor record
// depends on dcs_pkg
`default_nettype none

module dcs_step
  import dcs_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEF
) (
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  input  wire rec_t      rec,
  output logic           we,
  output rec_t           rec_next,
  output out_item_t      result
);

  localparam logic [4:0] MOTOR_LIM = 5'(MOTORS);

  logic        motor_ok;
  logic [31:0] elapsed;
  logic [15:0] gap;
  logic [5:0]  tgt;
  logic        wv;
  logic [5:0]  code;
  logic [1:0]  status;

  assign motor_ok = ({1'b0, item.motor} < MOTOR_LIM);
  assign elapsed  = item.now - rec.phase_start;
  assign gap      = (rec.phase == PH_CMD) ? cfg.cmd_gap_ticks : cfg.save_gap_ticks;

  always_comb begin
    rec_next = rec;
    wv       = 1'b0;
    code     = '0;
    status   = ST_OK;
    tgt      = item.direction;
    if (item.req_type == REQ_TOGGLE) begin
      tgt = (rec.dir_setting == cfg.dir_one_code) ? cfg.dir_two_code : cfg.dir_one_code;
    end

    case (item.req_type)
      REQ_TICK: begin
        if (rec.busy) begin
          case (rec.phase)
            PH_IDLE1, PH_IDLE2: begin
              if (elapsed < {16'h0, cfg.idle_ticks}) begin
                rec_next.idle = 1'b1;
              end else begin
                rec_next.phase       = (rec.phase == PH_IDLE1) ? PH_CMD : PH_SAVE;
                rec_next.sent_count  = '0;
                rec_next.phase_start = item.now;
              end
            end
            PH_CMD, PH_SAVE: begin
              if (elapsed < {16'h0, gap}) begin
                rec_next.idle = 1'b1;
              end else if (rec.sent_count < cfg.repeat_count) begin
                rec_next.idle        = 1'b0;
                wv                   = 1'b1;
                code = (rec.phase == PH_CMD) ? rec.target_code : cfg.save_code;
                rec_next.sent_count  = rec.sent_count + 4'd1;
                rec_next.phase_start = item.now;
              end else begin
                rec_next.sent_count = '0;
                if (rec.phase == PH_CMD) begin
                  rec_next.phase       = PH_IDLE2;
                  rec_next.phase_start = item.now;
                  rec_next.idle        = 1'b1;
                end else begin
                  rec_next.phase = PH_STOP;
                end
              end
            end
            default: begin
              // final phase, and unreachable codes behave the same
              rec_next.busy  = 1'b0;
              rec_next.phase = PH_IDLE1;
              rec_next.idle  = 1'b0;
            end
          endcase
        end
      end
      REQ_START, REQ_TOGGLE: begin
        if ((tgt != cfg.dir_one_code) && (tgt != cfg.dir_two_code)) begin
          status = ST_BAD_DIR;
        end else if (rec.busy) begin
          status = ST_BUSY;
        end else begin
          rec_next.target_code = tgt;
          rec_next.dir_setting = tgt;
          rec_next.busy        = 1'b1;
          rec_next.sent_count  = '0;
          rec_next.phase       = PH_IDLE1;
          rec_next.phase_start = item.now;
        end
      end
      default: begin
        // unused request type: report flags only
      end
    endcase
  end

  assign we = motor_ok;

  always_comb begin
    if (motor_ok) begin
      result.status      = status;
      result.bus_idle    = rec_next.idle;
      result.write_valid = wv;
      result.write_value = wv ? code : 6'd0;
      result.changing    = rec_next.busy;
    end else begin
      result = '0;
      result.status = ST_BAD_MOTOR;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dshot_direction_change_sequencer.sv =====
// dshot_direction_change_sequencer: top level with config registers, pipeline
// control and output register; depends on dcs_pkg, dcs_rec_mem, dcs_step
`default_nettype none

// Per-motor DShot spin-direction change sequencer. Start items (explicit or
// toggled direction) arm a motor; tick items carrying a time stamp walk that
// motor through first idle, direction commands, second idle, save commands
// and done. Every item gives exactly one result, in order. The block takes
// one item per clock cycle when the output side keeps up; the record memory
// read is registered when an item is accepted into stage 1, and the result
// lands in the output register and the record is written back when stage 1
// advances. Back-to-back items to the same motor see the fresh record through
// a forwarding path from the last write. Throughput is set by the single read
// and single write port of the record memory, one of each per cycle. Reset
// clears the record memory's valid bits at once, so no clearing pass is
// needed. Configuration registers may only be written while idle.
module dshot_direction_change_sequencer
  import dcs_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  cfg_t             cfg;
  logic             s1_valid;
  in_item_t         s1_item;
  logic             s1_adv;
  logic             in_acc;
  rec_t             rd_rec;
  rec_t             rec_next;
  logic             step_we;
  out_item_t        result;
  logic [IDX_W-1:0] rd_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_ticks     <= 16'd10;
      cfg.cmd_gap_ticks  <= 16'd1;
      cfg.save_gap_ticks <= 16'd1;
      cfg.repeat_count   <= 4'd10;
      cfg.dir_one_code   <= 6'd7;
      cfg.dir_two_code   <= 6'd8;
      cfg.save_code      <= 6'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_TICKS:     cfg.idle_ticks     <= cfg_data;
        REG_CMD_GAP_TICKS:  cfg.cmd_gap_ticks  <= cfg_data;
        REG_SAVE_GAP_TICKS: cfg.save_gap_ticks <= cfg_data;
        REG_REPEAT_COUNT:   cfg.repeat_count   <= cfg_data[3:0];
        REG_DIR_ONE_CODE:   cfg.dir_one_code   <= cfg_data[5:0];
        REG_DIR_TWO_CODE:   cfg.dir_two_code   <= cfg_data[5:0];
        REG_SAVE_CODE:      cfg.save_code      <= cfg_data[5:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // stage 1 moves into the output register whenever that register is free
  // or being emptied; the input side follows stage 1
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // out-of-range motors read entry zero; their record is ignored anyway
  assign rd_addr = ({1'b0, in_data.motor} < 5'(MOTORS)) ?
                   in_data.motor[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item <= in_data;
    end
  end

  dcs_rec_mem #(
    .MOTORS (MOTORS),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .wr_en   (s1_adv && step_we),
    .wr_addr (s1_item.motor[IDX_W-1:0]),
    .wr_rec  (rec_next),
    .rd_rec  (rd_rec)
  );

  dcs_step #(
    .MOTORS (MOTORS)
  ) u_step (
    .item     (s1_item),
    .cfg      (cfg),
    .rec      (rd_rec),
    .we       (step_we),
    .rec_next (rec_next),
    .result   (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  // a command write only happens while the motor's change keeps running
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.write_valid) |-> (out_data.changing && out_data.status == ST_OK))
    else $error("command write without change in progress");

  // a bad motor result carries no flags and no write
  a_bad_motor_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_BAD_MOTOR) |->
      (!out_data.bus_idle && !out_data.write_valid && !out_data.changing))
    else $error("bad motor result carries state");

  // input stalls only when a result is held back at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && s1_valid))
    else $error("input stalled without output backpressure");

  // no command code without a write
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.write_valid) |-> (out_data.write_value == 6'd0))
    else $error("write value set without write");

endmodule

`default_nettype wire
